FILE: hdl/h74eip_pkg.sv
// Shared types and constants for the Hamming (7,4) encode, error inject and pack block.
// Used by h74eip_encode and hamming74_encode_inject_pack_top; depends on nothing.
package h74eip_pkg;

  localparam int unsigned CODE_BITS = 7;
  localparam int unsigned PICK_BITS = 5;
  localparam int unsigned ACC_BITS  = 24;

  typedef logic [3:0]             nibble_t;
  typedef logic [CODE_BITS-1:0]   codeword_t;
  typedef logic [PICK_BITS-1:0]   pick_t;
  typedef logic [ACC_BITS-1:0]    acc_t;
  typedef logic [2:0]             rcount_t;
  typedef logic [1:0]             nbytes_t;

  // Byte counts held in the pending stage
  localparam nbytes_t NBYTES_ONE = 2'd1;
  localparam nbytes_t NBYTES_TWO = 2'd2;

  // Handshake status of the pending stage, shared with the output register
  typedef struct packed {
    logic valid;
    logic move;
    logic last;
  } pend_stat_t;

endpackage

FILE: hdl/h74eip_encode.sv
// Hamming (7,4) codeword generator with optional single-bit error injection.
// Depends on h74eip_pkg for the nibble, pick and codeword types.
module h74eip_encode (
  input  h74eip_pkg::nibble_t   nibble,
  input  h74eip_pkg::pick_t     pick,
  output h74eip_pkg::codeword_t codeword
);

  h74eip_pkg::codeword_t clean;
  h74eip_pkg::codeword_t flip_mask;
  logic                  flip_en;

  // Bit order: d0, d1, d2, p012, d3, p013, p023
  assign clean = {nibble[0] ^ nibble[2] ^ nibble[3],
                  nibble[0] ^ nibble[1] ^ nibble[3],
                  nibble[3],
                  nibble[0] ^ nibble[1] ^ nibble[2],
                  nibble[2],
                  nibble[1],
                  nibble[0]};

  // Flip only for picks that name a codeword bit
  assign flip_en   = (pick[4:3] == 2'b00) && (pick[2:0] != 3'b111);
  assign flip_mask = h74eip_pkg::codeword_t'(1) << pick[2:0];
  assign codeword  = flip_en ? (clean ^ flip_mask) : clean;

endmodule

FILE: hdl/hamming74_encode_inject_pack_top.sv
// Top level of the Hamming (7,4) encode, error inject and bit pack block.
// Depends on h74eip_pkg and instantiates h74eip_encode twice.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one request per data byte with
//   two error picks and a last_byte mark. The low nibble and then the high
//   nibble become 7-bit codewords; a pick below 7 flips that codeword bit.
//   The 14 bits join the residual stream bits and are packed LSB first.
//   Output channel (out_valid / out_ready) carries one packed byte per transfer;
//   last_out marks the flush byte that closes a message.
//   Each input request yields one or two full bytes, plus one flush byte when
//   last_byte is set (residual zero padded, or zero when nothing remains).
// Flow: each byte of a request passes from the pending stage into the single
//   byte-wide output register; a new request is accepted as the last byte of
//   the pending one moves out, so requests follow without a gap while
//   out_ready stays high.
// Stall: the pending stage and the output register hold while out_ready is
//   low; in_ready drops while the pending stage is full, unless its last byte moves.
// Reset (rst, synchronous): clear the residual, empty the pending stage and
//   the output register. A new message may start right after reset or flush.
module hamming74_encode_inject_pack_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic [4:0] flip_pick_low,
  input  logic [4:0] flip_pick_high,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packed_byte,
  output logic       last_out
);

  // Stream residual between requests
  logic [6:0]            residual_bits;
  h74eip_pkg::rcount_t   residual_count;

  // Pending stage: packed bytes of the last accepted request
  logic                  pend_valid;
  h74eip_pkg::acc_t      pend_acc;
  h74eip_pkg::nbytes_t   pend_n;
  logic                  pend_last;
  h74eip_pkg::pend_stat_t pstat;

  h74eip_pkg::codeword_t cw_low;
  h74eip_pkg::codeword_t cw_high;
  h74eip_pkg::acc_t      acc;
  h74eip_pkg::acc_t      acc_rest;
  logic [4:0]            total;
  logic                  two_full;
  logic                  in_accept;

  h74eip_encode u_enc_low (
    .nibble   (data_byte[3:0]),
    .pick     (flip_pick_low),
    .codeword (cw_low)
  );

  h74eip_encode u_enc_high (
    .nibble   (data_byte[7:4]),
    .pick     (flip_pick_high),
    .codeword (cw_high)
  );

  // Append both codewords above the residual bits
  assign acc = {17'd0, residual_bits}
             | ({17'd0, cw_low} << residual_count)
             | ({10'd0, cw_high, 7'd0} << residual_count);
  assign total    = {2'b00, residual_count} + 5'd14;
  assign two_full = total[4];
  assign acc_rest = two_full ? (acc >> 16) : (acc >> 8);

  // Move a byte from pending stage into the output register
  assign pstat.valid = pend_valid;
  assign pstat.move  = pend_valid && (!out_valid || out_ready);
  assign pstat.last  = pend_last && (pend_n == h74eip_pkg::NBYTES_ONE);

  assign in_ready  = !pstat.valid || (pstat.move && (pend_n == h74eip_pkg::NBYTES_ONE));
  assign in_accept = in_valid && in_ready;

  // Residual: advance on each request, drop on flush
  always_ff @(posedge clk) begin
    if (rst) begin
      residual_bits  <= '0;
      residual_count <= '0;
    end else if (in_accept) begin
      if (last_byte) begin
        residual_bits  <= '0;
        residual_count <= '0;
      end else begin
        residual_bits  <= acc_rest[6:0];
        residual_count <= total[2:0];
      end
    end
  end

  // Pending stage: load a request, then shift out one byte per move
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_n     <= '0;
    end else if (in_accept) begin
      pend_valid <= 1'b1;
      pend_n     <= (two_full ? h74eip_pkg::NBYTES_TWO : h74eip_pkg::NBYTES_ONE)
                    + h74eip_pkg::nbytes_t'(last_byte);
    end else if (pstat.move) begin
      pend_n <= pend_n - h74eip_pkg::NBYTES_ONE;
      if (pend_n == h74eip_pkg::NBYTES_ONE) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_acc  <= acc;
      pend_last <= last_byte;
    end else if (pstat.move) begin
      pend_acc  <= pend_acc >> 8;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pstat.move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pstat.move) begin
      packed_byte <= pend_acc[7:0];
      last_out    <= pstat.last;
    end
  end

  // A pending request always owes at least one byte
  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_n != 2'd0))
    else $error("pending stage valid with no bytes left");

  // An accepted request lands in the pending stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (pend_valid && (pend_n != 2'd0)))
    else $error("accepted request did not load the pending stage");

  // A flushing request leaves the residual cleared
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_byte) |=> ((residual_count == 3'd0) && (residual_bits == 7'd0)))
    else $error("residual not cleared after flush");

  // The flush byte is emitted only as the final byte of a pending request
  a_last_final: assert property (@(posedge clk) disable iff (rst)
    (pstat.move && pstat.last) |-> (pend_n == 2'd1))
    else $error("last_out raised before the final byte");

endmodule
